[hw/rtl/aslp_pkg.sv]
// Shared types, codes and arithmetic helpers for the sign-LMS predictor
// reconstruction block. No dependencies.
package aslp_pkg;

  // Request operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_RESID = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ORDER = 2'd0;
  localparam logic [1:0] CFG_SHIFT = 2'd1;
  localparam logic [1:0] CFG_WIDTH = 2'd2;
  localparam logic [1:0] CFG_INTEG = 2'd3;

  // Order code that selects the plain integrator
  localparam logic [4:0] ORDER_INTEG = 5'd31;
  // Frame position saturates here
  localparam logic [5:0] POS_MAX = 6'd33;

  // Accumulator operations of the shared MAC
  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

  // Sequencer states, one-hot
  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_DISP = 15'b000000000000010,
    ST_TWT  = 15'b000000000000100,
    ST_SRD  = 15'b000000000001000,
    ST_SDIF = 15'b000000000010000,
    ST_SMUL = 15'b000000000100000,
    ST_SDRN = 15'b000000001000000,
    ST_FRND = 15'b000000010000000,
    ST_FY   = 15'b000000100000000,
    ST_ARD  = 15'b000001000000000,
    ST_ADIF = 15'b000010000000000,
    ST_AMUL = 15'b000100000000000,
    ST_HWR  = 15'b001000000000000,
    ST_OUT  = 15'b010000000000000,
    ST_SPR  = 15'b100000000000000
  } state_t;

  // Arithmetic shift right of a 32-bit word
  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [3:0] s);
    return 32'($signed(x) >>> s);
  endfunction

  // Sign-wrap to the channel width (clamped to 8..32)
  function automatic logic [31:0] wrap_width(input logic [31:0] x, input logic [5:0] cw);
    logic [5:0]  w;
    logic [31:0] r;
    logic        sb;
    if (cw < 6'd8) begin
      w = 6'd8;
    end else if (cw > 6'd32) begin
      w = 6'd32;
    end else begin
      w = cw;
    end
    sb = x[5'(w - 6'd1)];
    for (int i = 0; i < 32; i++) begin
      r[i] = (6'(i) < w) ? x[i] : sb;
    end
    return r;
  endfunction

endpackage

[hw/rtl/aslp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aslp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/aslp_mac.sv]
// Shared multiply-accumulate unit: registered 32x16 product (low 32 bits)
// feeding a wrapping 32-bit accumulator. Depends on aslp_pkg.
module aslp_mac
  import aslp_pkg::*;
(
  input  logic               clk,
  input  mac_ctrl_t          ctrl,
  input  logic [31:0]        mul_a,
  input  logic signed [15:0] mul_b,
  input  logic [31:0]        load_val,
  output logic [31:0]        acc
);

  logic [31:0]        prod_r;
  logic [31:0]        acc_r;
  logic signed [47:0] prod_full;

  // Multiplier stage
  assign prod_full = $signed(mul_a) * mul_b;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_full[31:0];
    end
  end

  // Accumulator stage
  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      ACC_LOAD: acc_r <= load_val;
      ACC_ADD:  acc_r <= acc_r + prod_r;
      ACC_SUB:  acc_r <= acc_r - prod_r;
      default:  acc_r <= acc_r;
    endcase
  end

  assign acc = acc_r;

endmodule

[hw/rtl/adaptive_sign_lms_predictor_reconstruct.sv]
// Top level of the sign-LMS predictor reconstruction block: sequencer,
// history/coefficient RAMs and shared MAC. Depends on aslp_pkg, aslp_ram, aslp_mac.
//
// One residual request gives one sample. Start-frame and coefficient-load
// requests finish in the cycle they are accepted and give no result. A
// residual request occupies the block until its sample is loaded into the
// output register, and stalls there while the result side holds back the
// previous sample. Pass-through and the integrator path (also taken early in
// a frame) are short; a FIR order N (at most 30, the largest FIR order) reads
// N taps for the prediction and up to N for adaptation. Each tap costs a RAM read, a difference
// and one pass through the single shared multiplier; adaptation stops early
// once the residual's sign is spent. The sample history lives in a circular
// RAM whose fill count stands in for the all-zero reset; coefficients must
// be loaded before use. A finished sample waits in the output register
// while the next request is accepted.
module adaptive_sign_lms_predictor_reconstruct
  import aslp_pkg::*;
#(
  parameter int MAX_ORDER = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // Request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [4:0]         in_coef_index,
  input  logic signed [15:0] in_coef_value,
  input  logic signed [31:0] in_residual,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_sample,
  // Configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data
);

  localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CW = $clog2(MAX_ORDER + 1);

  // Configuration registers
  logic [4:0] order_r;
  logic [3:0] qsh_r;
  logic [5:0] cw_r;
  logic       intf_r;

  // Control state
  state_t        state_r, state_nxt;
  logic [5:0]    pos_r, pos_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          first_r, first_nxt;
  logic          hv_r;
  logic          out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [31:0] x_r, x_nxt;
  logic [31:0] integ_r, integ_nxt;
  logic [31:0] top_r, top_nxt;
  logic [31:0] diff_r, diff_nxt;
  logic [31:0] term_r, term_nxt;
  logic [31:0] t_r, t_nxt;
  logic [31:0] y_r, y_nxt;
  logic [31:0] out_sample_r, out_sample_nxt;

  // RAM and MAC hookup
  logic          hist_we, hist_re;
  logic [AW-1:0] hist_waddr, hist_raddr, hist_ridx;
  logic [31:0]   hist_rdata;
  logic          coef_we, coef_re;
  logic [AW-1:0] coef_waddr;
  logic [15:0]   coef_wdata, coef_rdata;
  mac_ctrl_t     mac_ctrl;
  logic [31:0]   mac_a, mac_load, acc;
  logic [15:0]   mac_b;

  // Helpers
  logic          in_acc, cfg_acc;
  logic [AW-1:0] ford;
  logic          is_integ, short_path, pass_path;
  logic [AW:0]   asum;
  logic [31:0]   hval, dd, hneg, half, integ_acc;
  logic          neg, up, brk, dz;
  logic [AW-1:0] kdist;

  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_sample = out_sample_r;

  // Effective FIR order, clamped to the storage
  assign ford = ({1'b0, order_r} > 6'(MAX_ORDER - 1)) ? AW'(MAX_ORDER - 1) : AW'(order_r);
  assign is_integ   = (order_r == ORDER_INTEG);
  assign pass_path  = (pos_r == 6'd0) || (ford == '0);
  assign short_path = is_integ || (pos_r <= 6'(ford));

  // Circular history addressing: tap k sits k entries past the newest
  assign asum = {1'b0, head_r} + {1'b0, hist_ridx};
  assign hist_raddr = (asum >= (AW+1)'(MAX_ORDER)) ? AW'(asum - (AW+1)'(MAX_ORDER))
                                                   : asum[AW-1:0];
  assign head_nxt = (head_r == '0) ? AW'(MAX_ORDER - 1) : head_r - 1'b1;
  assign hist_waddr = head_nxt;

  // Taps not yet filled since reset read as zero
  assign hval = hv_r ? hist_rdata : 32'd0;

  // Adaptation arithmetic
  assign neg  = x_r[31];
  assign dd   = top_r - hval;
  assign hneg = hval - top_r;
  assign dz   = (dd == 32'd0);
  assign up   = dd[31] ^ neg;
  assign brk  = neg ? !acc[31] : ((acc == 32'd0) || acc[31]);
  assign kdist = ford - k_r;
  assign half = (qsh_r == 4'd0) ? 32'd0 : (32'd1 << (qsh_r - 4'd1));
  assign integ_acc = (pos_r == 6'd0) ? 32'(in_residual)
                                     : wrap_width(32'(in_residual) + integ_r, cw_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    fill_nxt       = fill_r;
    k_nxt          = k_r;
    first_nxt      = first_r;
    out_valid_nxt  = out_valid_r;
    x_nxt          = x_r;
    integ_nxt      = integ_r;
    top_nxt        = top_r;
    diff_nxt       = diff_r;
    term_nxt       = term_r;
    t_nxt          = t_r;
    y_nxt          = y_r;
    out_sample_nxt = out_sample_r;
    hist_we        = 1'b0;
    hist_re        = 1'b0;
    hist_ridx      = k_r;
    coef_we        = 1'b0;
    coef_re        = 1'b0;
    coef_waddr     = k_r;
    coef_wdata     = dz ? coef_rdata : (up ? coef_rdata + 16'd1 : coef_rdata - 16'd1);
    mac_ctrl       = '{mul_en: 1'b0, acc_op: ACC_HOLD};
    mac_a          = diff_r;
    mac_b          = coef_rdata;
    mac_load       = 32'd0;

    // Result register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_operation)
            OP_START: pos_nxt = 6'd0;
            OP_LOAD: begin
              coef_we    = ({1'b0, in_coef_index} < 6'(MAX_ORDER));
              coef_waddr = AW'(in_coef_index);
              coef_wdata = in_coef_value;
            end
            OP_RESID: begin
              if (intf_r) begin
                integ_nxt = integ_acc;
                x_nxt     = integ_acc;
              end else begin
                x_nxt     = in_residual;
              end
              state_nxt = ST_DISP;
            end
            default: ;
          endcase
        end
      end
      // Pick the path and fetch the oldest tap (or the newest for integrating)
      ST_DISP: begin
        if (pass_path) begin
          y_nxt     = x_r;
          state_nxt = ST_HWR;
        end else begin
          hist_re   = 1'b1;
          hist_ridx = short_path ? '0 : ford;
          state_nxt = ST_TWT;
        end
      end
      ST_TWT: begin
        if (short_path) begin
          y_nxt     = wrap_width(x_r + hval, cw_r);
          state_nxt = ST_HWR;
        end else begin
          top_nxt         = hval;
          mac_ctrl.acc_op = ACC_LOAD;
          mac_load        = 32'd0;
          k_nxt           = '0;
          first_nxt       = 1'b1;
          state_nxt       = ST_SRD;
        end
      end
      // Prediction sum, one tap per pass
      ST_SRD: begin
        hist_re = 1'b1;
        coef_re = 1'b1;
        if (!first_r) begin
          mac_ctrl.acc_op = ACC_ADD;
        end
        state_nxt = ST_SDIF;
      end
      ST_SDIF: begin
        diff_nxt  = hval - top_r;
        state_nxt = ST_SMUL;
      end
      ST_SMUL: begin
        mac_ctrl.mul_en = 1'b1;
        first_nxt       = 1'b0;
        if (k_r == ford - 1'b1) begin
          state_nxt = ST_SDRN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_SRD;
        end
      end
      ST_SDRN: begin
        mac_ctrl.acc_op = ACC_ADD;
        state_nxt       = ST_FRND;
      end
      // Round and shift the sum
      ST_FRND: begin
        t_nxt     = asr32(acc + half, qsh_r);
        state_nxt = ST_FY;
      end
      ST_FY: begin
        y_nxt = wrap_width(x_r + top_r + t_r, cw_r);
        if (x_r != 32'd0) begin
          mac_ctrl.acc_op = ACC_LOAD;
          mac_load        = x_r;
          k_nxt           = ford - 1'b1;
          first_nxt       = 1'b1;
          state_nxt       = ST_ARD;
        end else begin
          state_nxt = ST_HWR;
        end
      end
      // Sign-sign adaptation, next-to-oldest tap first
      ST_ARD: begin
        hist_re = 1'b1;
        coef_re = 1'b1;
        if (!first_r) begin
          mac_ctrl.acc_op = ACC_SUB;
        end
        state_nxt = ST_ADIF;
      end
      ST_ADIF: begin
        if (!first_r && brk) begin
          state_nxt = ST_HWR;
        end else begin
          coef_we   = 1'b1;
          term_nxt  = up ? hneg : dd;
          state_nxt = ST_AMUL;
        end
      end
      ST_AMUL: begin
        mac_ctrl.mul_en = 1'b1;
        mac_a           = asr32(term_r, qsh_r);
        mac_b           = 16'(kdist);
        first_nxt       = 1'b0;
        if (k_r == '0) begin
          state_nxt = ST_HWR;
        end else begin
          k_nxt     = k_r - 1'b1;
          state_nxt = ST_ARD;
        end
      end
      // Push the new sample into the history
      ST_HWR: begin
        hist_we = 1'b1;
        if (fill_r != CW'(MAX_ORDER)) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + 6'd1;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = y_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= 6'd0;
      head_r      <= '0;
      fill_r      <= '0;
      k_r         <= '0;
      first_r     <= 1'b0;
      hv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      integ_r     <= 32'd0;
      order_r     <= 5'd0;
      qsh_r       <= 4'd9;
      cw_r        <= 6'd16;
      intf_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      if (hist_we) begin
        head_r <= head_nxt;
      end
      if (hist_re) begin
        hv_r <= (CW'(hist_ridx) < fill_r);
      end
      if (cfg_acc) begin
        case (cfg_index)
          CFG_ORDER: order_r <= cfg_data[4:0];
          CFG_SHIFT: qsh_r   <= cfg_data[3:0];
          CFG_WIDTH: cw_r    <= cfg_data;
          CFG_INTEG: intf_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    top_r        <= top_nxt;
    diff_r       <= diff_nxt;
    term_r       <= term_nxt;
    t_r          <= t_nxt;
    y_r          <= y_nxt;
    out_sample_r <= out_sample_nxt;
  end

  // Sample history, circular
  aslp_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (y_r),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Coefficient bank
  aslp_ram #(.WIDTH(16), .DEPTH(MAX_ORDER)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .re    (coef_re),
    .raddr (k_r),
    .rdata (coef_rdata)
  );

  // Shared multiply-accumulate
  aslp_mac u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .mul_a    (mac_a),
    .mul_b    (mac_b),
    .load_val (mac_load),
    .acc      (acc)
  );

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_ORDER))
    else $error("history fill count overran depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("frame position past saturation");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(MAX_ORDER - 1))
    else $error("history head out of range");

  a_resid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == OP_RESID) |=> !in_ready)
    else $error("residual request did not occupy the sequencer");

  a_hist_once: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |=> (state_r == ST_OUT) && !hist_we)
    else $error("history written outside the commit step");

endmodule
